>>> rtl/mbps_pkg.sv
// Shared constants and types of the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

    // Largest pattern the window is built for
    localparam int MAX_PATTERN_BYTES_DFLT = 16;

    // Widths fixed by the register and field definitions
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PAT_BITS     = 128;
    localparam int LEN_W        = 5;
    localparam int OFFSET_W     = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_LO  = 3'd0,
        CFG_VALUE_HI  = 3'd1,
        CFG_MASK_LO   = 3'd2,
        CFG_MASK_HI   = 3'd3,
        CFG_LENGTH    = 3'd4
    } t_cfg_idx;

    // Pattern setup as seen by the compare logic
    typedef struct packed {
        logic [PAT_BITS-1:0] value;
        logic [PAT_BITS-1:0] mask;
        logic [LEN_W-1:0]    length;   // already clamped to 1..max
    } t_pattern_cfg;

endpackage

`default_nettype wire

>>> rtl/mbps_in_if.sv
// Input channel of the scanner: one buffer byte per word.
`default_nettype none

interface mbps_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] start_offset;
    logic        last_byte;

    modport source (output valid, data_byte, first_byte, start_offset, last_byte,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, start_offset, last_byte,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/mbps_out_if.sv
// Result channel of the scanner: found flag and match offset per word.
`default_nettype none

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

>>> rtl/mbps_cfg_regs.sv
// Pattern configuration registers with length clamping.
`default_nettype none

module mbps_cfg_regs #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbps_pkg::t_pattern_cfg             o_cfg
);
    import mbps_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    logic [CFG_DATA_W-1:0] r_value_lo, r_value_hi, r_mask_lo, r_mask_hi;
    logic [LEN_W-1:0]      r_length;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_lo <= '0;
            r_value_hi <= '0;
            r_mask_lo  <= '0;
            r_mask_hi  <= '0;
            r_length   <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_VALUE_LO: r_value_lo <= i_cfg_data;
                CFG_VALUE_HI: r_value_hi <= i_cfg_data;
                CFG_MASK_LO:  r_mask_lo  <= i_cfg_data;
                CFG_MASK_HI:  r_mask_hi  <= i_cfg_data;
                CFG_LENGTH:   r_length   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero length acts as one, oversize as the window depth
    always_comb begin
        o_cfg.value = {r_value_hi, r_value_lo};
        o_cfg.mask  = {r_mask_hi, r_mask_lo};
        if (r_length == '0) begin
            o_cfg.length = LEN_W'(1);
        end else if (r_length > MAX_LEN) begin
            o_cfg.length = MAX_LEN;
        end else begin
            o_cfg.length = r_length;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mbps_match.sv
// Parallel masked compare of the byte window against the pattern.
`default_nettype none

module mbps_match #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire mbps_pkg::t_pattern_cfg i_cfg,
    input  wire logic [7:0]        i_win [MAX_PATTERN_BYTES],
    output logic                   o_hit
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [MAX_PATTERN_BYTES-1:0] lane_ok;

    // Pattern byte j lines up with window slot length-1-j (slot 0 is newest)
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_lane
        logic [LEN_W-1:0] pos;
        logic [7:0]       win_byte;
        assign pos      = i_cfg.length - LEN_W'(j) - LEN_W'(1);
        assign win_byte = i_win[pos[IDX_W-1:0]];
        assign lane_ok[j] = (LEN_W'(j) >= i_cfg.length) ||
                            ((win_byte & i_cfg.mask[8*j +: 8]) == i_cfg.value[8*j +: 8]);
    end

    assign o_hit = &lane_ok;

endmodule

`default_nettype wire

>>> rtl/masked_byte_pattern_scanner_core.sv
// Top level of the masked byte pattern scanner.
// Usage:
//   i_in carries one buffer byte per word; first_byte opens a scan and loads
//   start_offset as the offset of that byte. last_byte closes the buffer.
//   o_out carries at most one word per scan: found=1 with the offset of the
//   first matching byte, or found=0 / offset 0 on the last byte if none hit.
//   Pattern registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   no scan word is in flight.
// Timing:
//   A byte is taken into the input register, and when it advances its result
//   (if any) is written into the output register, which drives o_out.valid.
//   One byte per cycle sustained while no result waits on a stalled receiver;
//   the single window compare plus the offset adder set the cycle.
// Reset clears the window, byte count, scan state and both pipeline valids;
// the pattern comes back as length one, value and mask zero.
// When the receiver stalls with a result pending, the input register still
// drains bytes that produce no result; a byte that would produce one waits.
`default_nettype none

module masked_byte_pattern_scanner_core #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DFLT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mbps_in_if.sink                              i_in,
    mbps_out_if.source                           o_out
);
    import mbps_pkg::*;

    localparam logic [OFFSET_W-1:0] SEEN_MAX = '1;

    t_pattern_cfg cfg;

    // Input word register
    logic                r_in_valid;
    logic [7:0]          r_in_data;
    logic                r_in_first;
    logic [OFFSET_W-1:0] r_in_start;
    logic                r_in_last;

    // Scan state
    logic [7:0]          r_win [MAX_PATTERN_BYTES];
    logic [7:0]          n_win [MAX_PATTERN_BYTES];
    logic [OFFSET_W-1:0] r_seen, n_seen;
    logic [OFFSET_W-1:0] r_base, n_base;
    logic                r_done, n_done;

    // Result register
    logic                r_out_valid;
    logic                r_out_found;
    logic [OFFSET_W-1:0] r_out_offset;

    logic                advance;
    logic                win_hit;
    logic                hit;
    logic                emit;
    logic [OFFSET_W-1:0] seen_start;
    logic                done_start;
    logic [OFFSET_W-1:0] hit_offset;

    mbps_cfg_regs #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mbps_match #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_match (
        .i_cfg (cfg),
        .i_win (n_win),
        .o_hit (win_hit)
    );

    // Handshake: stage moves when the result slot is free or draining, or the byte emits no result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready || !emit);
    assign i_in.ready = !r_in_valid || advance;

    // Next window: shift in the registered byte
    always_comb begin
        n_win[0] = r_in_data;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // Per-byte scan update
    always_comb begin
        seen_start = r_in_first ? '0 : r_seen;
        n_base     = r_in_first ? r_in_start : r_base;
        done_start = r_in_first ? 1'b0 : r_done;
        n_seen     = (seen_start == SEEN_MAX) ? seen_start : seen_start + OFFSET_W'(1);
        hit        = (n_seen >= OFFSET_W'(cfg.length)) && win_hit;
        emit       = r_in_valid && !done_start && (hit || r_in_last);
        n_done     = done_start || hit || r_in_last;
        hit_offset = n_base + n_seen - OFFSET_W'(cfg.length);
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_data  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
            r_in_start <= i_in.start_offset;
            r_in_last  <= i_in.last_byte;
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                r_win[k] <= '0;
            end
            r_seen <= '0;
            r_base <= '0;
            r_done <= 1'b0;
        end else if (advance) begin
            r_win  <= n_win;
            r_seen <= n_seen;
            r_base <= n_base;
            r_done <= n_done;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out_found  <= hit;
            r_out_offset <= hit ? hit_offset : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.match_offset = r_out_offset;

`ifndef NO_ASSERTIONS
    // Not-found results always carry offset zero
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_offset == '0))
        else $error("not-found result with nonzero offset");

    // A result closes the scan
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> r_done)
        else $error("scan still open after a result");

    // A held input word is not lost or altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)
                                      && $stable(r_in_start)))
        else $error("stalled input word overwritten");

    // A pending result is never overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_offset)
                                           && $stable(r_out_found)))
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

>>> tb/mbps_scan_checker.sv
// Scoreboard for the byte pattern scanner: predicts each scan result and checks o_out words.
module mbps_scan_checker
    import mbps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mbps_in_if                         in_mon,
    mbps_out_if                        out_mon,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int WINDOW_DEPTH = MAX_PATTERN_BYTES_DFLT;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } scan_result_t;

    // Shadow copy of the pattern registers
    logic [PAT_BITS-1:0] pat_value;
    logic [PAT_BITS-1:0] pat_mask;
    logic [LEN_W-1:0]    pat_len_raw;

    // Shadow copy of the scan state; window[0] is the newest byte
    logic [7:0]          window [WINDOW_DEPTH];
    logic [31:0]         bytes_seen;
    logic [OFFSET_W-1:0] base_offset;
    logic                scan_closed;

    scan_result_t expected_hits [$];
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Length register as the compare uses it: 0 acts as 1, large values clamp
    function automatic int unsigned active_length();
        if (pat_len_raw == '0)
            return 1;
        if (pat_len_raw > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return pat_len_raw;
    endfunction

    // Pattern byte 0 lines up with the oldest of the last len bytes
    function automatic logic window_hit(int unsigned len);
        logic [7:0] b;
        logic [7:0] v;
        logic [7:0] m;
        for (int j = 0; j < len; j++) begin
            b = window[len - 1 - j];
            v = pat_value[8*j +: 8];
            m = pat_mask[8*j +: 8];
            if ((b & m) != v)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the scan by one byte and queue the result it causes, if any
    task automatic take_byte(input logic [7:0] data, input logic is_first,
                             input logic [OFFSET_W-1:0] start, input logic is_last);
        int unsigned  len;
        scan_result_t hit;
        len = active_length();
        if (is_first) begin
            foreach (window[k])
                window[k] = 8'h00;
            bytes_seen  = '0;
            base_offset = start;
            scan_closed = 1'b0;
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = data;
        if (bytes_seen != '1)
            bytes_seen++;
        if (scan_closed)
            return;
        if (bytes_seen >= len && window_hit(len)) begin
            scan_closed      = 1'b1;
            hit.found        = 1'b1;
            hit.match_offset = base_offset + bytes_seen - len;
            expected_hits.push_back(hit);
        end else if (is_last) begin
            scan_closed = 1'b1;
            hit         = '0;
            expected_hits.push_back(hit);
        end
    endtask

    always @(posedge i_clk) begin
        scan_result_t want;
        if (!i_rst_n) begin
            pat_value   = '0;
            pat_mask    = '0;
            pat_len_raw = LEN_W'(1);
            foreach (window[k])
                window[k] = 8'h00;
            bytes_seen  = '0;
            base_offset = '0;
            scan_closed = 1'b0;
            expected_hits.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VALUE_LO: pat_value[63:0]   = i_cfg_data;
                    CFG_VALUE_HI: pat_value[127:64] = i_cfg_data;
                    CFG_MASK_LO:  pat_mask[63:0]    = i_cfg_data;
                    CFG_MASK_HI:  pat_mask[127:64]  = i_cfg_data;
                    CFG_LENGTH:   pat_len_raw       = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // Result side first: a byte taken this edge cannot answer this edge
            if (out_mon.valid && out_mon.ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result word: found %0d, match_offset 0x%08h",
                           out_mon.found, out_mon.match_offset);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (out_mon.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, out_mon.found);
                        fail_count++;
                    end
                    if (out_mon.match_offset !== want.match_offset) begin
                        $error("match_offset: expected 0x%08h, actual 0x%08h",
                               want.match_offset, out_mon.match_offset);
                        fail_count++;
                    end
                end
            end

            if (in_mon.valid && in_mon.ready)
                take_byte(in_mon.data_byte, in_mon.first_byte, in_mon.start_offset,
                          in_mon.last_byte);
        end
        pending_count = expected_hits.size();
    end

endmodule

>>> tb/tb_top.sv
// Top of the scanner testbench: clock, reset, pattern setup, byte stimulus and verdict.
module tb_top;
    import mbps_pkg::*;

    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the input
    localparam int DRAIN_CYCLES = 6;     // block latency plus margin before a setup change
    localparam int RANDOM_ITEMS = 850;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbps_in_if  in_ch ();
    mbps_out_if out_ch ();

    int fail_count;
    int pending_words;
    int results_taken = 0;
    int bytes_sent = 0;
    bit steady_send = 0;

    // Mirror of the loaded pattern, used to plant matches in the stream
    logic [PAT_BITS-1:0] cur_value = '0;
    logic [PAT_BITS-1:0] cur_mask = '0;
    int unsigned         cur_len = 1;

    masked_byte_pattern_scanner_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mbps_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready)
            results_taken <= results_taken + 1;

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte word and return at the falling edge after it is taken
    task automatic send_byte(input logic [7:0] data, input logic is_first,
                             input logic [31:0] start, input logic is_last);
        int unsigned gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.first_byte   <= is_first;
        in_ch.start_offset <= start;
        in_ch.last_byte    <= is_last;
        do
            @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Wait until the block is idle, then write all five pattern registers
    task automatic load_pattern(input logic [PAT_BITS-1:0] value,
                                input logic [PAT_BITS-1:0] mask,
                                input logic [CFG_DATA_W-1:0] len_word);
        t_cfg_idx              reg_order [5] = '{CFG_VALUE_LO, CFG_VALUE_HI, CFG_MASK_LO,
                                                 CFG_MASK_HI, CFG_LENGTH};
        logic [CFG_DATA_W-1:0] reg_word;
        logic [LEN_W-1:0]      raw_len;
        in_ch.valid <= 1'b0;
        while (pending_words != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        foreach (reg_order[r]) begin
            case (reg_order[r])
                CFG_VALUE_LO: reg_word = value[63:0];
                CFG_VALUE_HI: reg_word = value[127:64];
                CFG_MASK_LO:  reg_word = mask[63:0];
                CFG_MASK_HI:  reg_word = mask[127:64];
                default:      reg_word = len_word;
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= reg_order[r];
            cfg_data <= reg_word;
            @(negedge i_clk);
        end
        cfg_we    <= 1'b0;
        cur_value = value;
        cur_mask  = mask;
        raw_len   = len_word[LEN_W-1:0];
        cur_len   = (raw_len == 0) ? 1 : ((raw_len > MAX_PATTERN_BYTES_DFLT) ?
                    MAX_PATTERN_BYTES_DFLT : raw_len);
    endtask

    // Pick a random pattern setup, covering wildcard styles and length extremes
    task automatic load_random_pattern();
        logic [PAT_BITS-1:0]   value;
        logic [PAT_BITS-1:0]   mask;
        logic [CFG_DATA_W-1:0] len_word;
        logic [LEN_W-1:0]      raw_len;
        int unsigned           style;
        logic [7:0]            m;
        style = $urandom_range(0, 4);
        for (int j = 0; j < MAX_PATTERN_BYTES_DFLT; j++) begin
            case (style)
                0:       m = 8'hFF;
                1:       m = 8'h00;
                2: begin
                    case ($urandom_range(0, 3))
                        0:       m = 8'hFF;
                        1:       m = 8'hF0;
                        2:       m = 8'h0F;
                        default: m = 8'h00;
                    endcase
                end
                default: m = 8'($urandom);
            endcase
            mask[8*j +: 8] = m;
            // A value bit outside its mask makes that lane unmatchable
            value[8*j +: 8] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : (8'($urandom) & m);
        end
        case ($urandom_range(0, 9))
            0:       raw_len = LEN_W'(0);
            1:       raw_len = LEN_W'(1);
            2:       raw_len = LEN_W'(16);
            3:       raw_len = LEN_W'($urandom_range(17, 31));
            default: raw_len = LEN_W'($urandom_range(1, 16));
        endcase
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = raw_len;
        load_pattern(value, mask, len_word);
    endtask

    // One buffer: mostly well formed, often carrying a planted match
    task automatic send_scan();
        int unsigned scan_len;
        int unsigned plant_at;
        int unsigned j;
        logic        with_first;
        logic        with_last;
        logic        plant;
        logic        is_first;
        logic        is_last;
        logic [31:0] start;
        logic [7:0]  data;
        logic [7:0]  m;
        scan_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 20);
        with_first = ($urandom_range(0, 9) != 0);
        with_last  = ($urandom_range(0, 9) != 0);
        plant      = ($urandom_range(0, 2) != 0);
        plant_at   = $urandom_range(0, scan_len - 1);
        start      = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) :
                     32'($urandom);
        for (int i = 0; i < scan_len; i++) begin
            data = 8'($urandom);
            if (plant && i >= plant_at && i - plant_at < cur_len) begin
                j    = i - plant_at;
                m    = cur_mask[8*j +: 8];
                data = (data & ~m) | cur_value[8*j +: 8];
            end
            is_first = (with_first && i == 0) || ($urandom_range(0, 59) == 0);
            is_last  = (with_last && i == scan_len - 1) || ($urandom_range(0, 59) == 0);
            send_byte(data, is_first, (with_first && i == 0) ? start : 32'($urandom), is_last);
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [PAT_BITS-1:0] seq_value;
        int                  phase_end;
        int                  random_start;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.first_byte   = 1'b0;
        in_ch.start_offset = '0;
        in_ch.last_byte    = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_VALUE_LO;
        cfg_data           = '0;
        i_rst_n            = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pattern matches any byte: a stray byte before a scan, then a
        // byte after its result, then a one-byte scan at the top offset
        send_byte(8'hFF, 1'b0, 32'h1234_5678, 1'b0);
        send_byte(8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_byte(8'h5A, 1'b1, 32'hFFFF_FFFF, 1'b1);

        // Full 16-byte exact pattern matching on the last byte, offset wraps
        for (int j = 0; j < MAX_PATTERN_BYTES_DFLT; j++)
            seq_value[8*j +: 8] = 8'(8'hA0 + j);
        load_pattern(seq_value, '1, 64'd16);
        send_byte(8'h00, 1'b1, 32'hFFFF_FFFE, 1'b0);
        send_byte(8'h00, 1'b0, 32'h0000_0000, 1'b0);
        for (int j = 0; j < MAX_PATTERN_BYTES_DFLT; j++)
            send_byte(8'(8'hA0 + j), 1'b0, 32'($urandom), j == MAX_PATTERN_BYTES_DFLT - 1);

        // Length zero acts as one; low nibble is a wildcard
        load_pattern(128'h50, 128'hF0, 64'hFFFF_FFFF_FFFF_FFE0);
        send_byte(8'h5A, 1'b1, 32'h0000_0007, 1'b1);
        send_byte(8'h3A, 1'b1, 32'h8000_0000, 1'b1);

        // Random phases, each under its own pattern
        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_ITEMS) begin
            load_random_pattern();
            steady_send = ($urandom_range(0, 3) == 0);
            phase_end   = bytes_sent;
            while (bytes_sent < phase_end + $urandom_range(40, 110))
                send_scan();
        end

        in_ch.valid <= 1'b0;
        while (pending_words != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, eager stretches, and one long hold-off
    initial begin
        bit          long_hold_done;
        int unsigned eager_left;
        int unsigned stall;
        long_hold_done = 0;
        eager_left     = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && results_taken >= 25) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1;
            end else if (eager_left > 0) begin
                out_ch.ready <= 1'b1;
                eager_left--;
                @(negedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
                if ($urandom_range(0, 31) == 0)
                    eager_left = $urandom_range(50, 200);
            end
        end
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/mbps_pkg.sv
rtl/mbps_in_if.sv
rtl/mbps_out_if.sv
rtl/mbps_cfg_regs.sv
rtl/mbps_match.sv
rtl/masked_byte_pattern_scanner_core.sv
tb/mbps_scan_checker.sv
tb/tb_top.sv
